[design/clock_cache_tag_engine_assert.svh]
// Assertion macros for the tag engine controller.
`ifndef CLOCK_CACHE_TAG_ENGINE_ASSERT_SVH
`define CLOCK_CACHE_TAG_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is low.
`define CTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked property, active during reset too.
`define CTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/cte_pkg.sv]
// Types, constants and controller/datapath interface of the tag engine.
package cte_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CFG_W      = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam int EXT_W      = (CFG_W > SLOT_W + 1) ? CFG_W : SLOT_W + 1;
    localparam int FILE_W     = 16;
    localparam int OFF_W      = 24;
    localparam int TAG_W      = FILE_W + OFF_W;
    localparam int CNT_W      = 32;
    localparam int SLOT_OUT_W = 6;

    // counter indexes
    localparam int CNT_RD_HIT  = 0;
    localparam int CNT_RD_MISS = 1;
    localparam int CNT_WR_HIT  = 2;
    localparam int CNT_WR_MISS = 3;
    localparam int CNT_NUM     = 4;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TRUNC = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [FILE_W-1:0]   file_id;
        logic [OFF_W-1:0]    block_offset;
        logic [OFF_W-1:0]    new_size;
        logic                fetch_failed;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  allocated;
        logic                  failed;
        logic [CNT_W-1:0]      read_hits;
        logic [CNT_W-1:0]      read_misses;
        logic [CNT_W-1:0]      write_hits;
        logic [CNT_W-1:0]      write_misses;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SWEEP,
        ST_FILL,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic ram_rd;
        logic idx_inc;
        logic hit_set;
        logic trunc_clr;
        logic fail_set;
        logic hand_wrap;
        logic hand_step;
        logic fill;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_trunc;
        logic is_read;
        logic fetch_failed;
        logic match;
        logic last;
        logic hand_recent;
    } t_dp_status;

endpackage

[design/clock_cache_tag_engine.sv]
// A lookup reads then compares slots from 0 and finishes on the first match; an allocating miss
// scans all n slots, sweeps past and clears each recent mark, then fills; a failed read miss or a
// truncate finishes after the full scan. One request at a time; the scan reads one slot at a time.
// busy drops with the result strobe, so the next request can be taken in that cycle.
// Reset clears valid/recent marks, hand and counters and sets the slot count to 64; the tag
// RAM is not cleared. o_done is a one-cycle strobe and cannot be held off.
module clock_cache_tag_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cte_pkg::t_req             i_req,
    output logic                      o_done,
    output cte_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_we,
    input  logic [cte_pkg::CFG_W-1:0] i_cfg_data
);

    cte_pkg::t_dp_cmd    cmd;
    cte_pkg::t_dp_status status;

    cte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    cte_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

[design/cte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/cte_datapath.sv]
// Tag datapath: request latch, tag memory, valid/recent marks, hand and counters.
module cte_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cte_pkg::t_req            i_req,
    input  logic                     i_cfg_we,
    input  logic [cte_pkg::CFG_W-1:0] i_cfg_data,
    input  cte_pkg::t_dp_cmd         i_cmd,
    output cte_pkg::t_dp_status      o_status,
    output logic                     o_done,
    output cte_pkg::t_rsp            o_rsp
);

    cte_pkg::t_req                    r_req;
    logic [cte_pkg::CFG_W-1:0]        r_slots_in_use;
    logic [cte_pkg::SLOT_W-1:0]       r_idx;
    logic [cte_pkg::SLOT_W-1:0]       r_hand;
    logic [cte_pkg::MAX_SLOTS-1:0]    r_valid;
    logic [cte_pkg::MAX_SLOTS-1:0]    r_recent;
    logic [cte_pkg::CNT_NUM-1:0][cte_pkg::CNT_W-1:0] r_cnt;
    logic [cte_pkg::CNT_NUM-1:0][cte_pkg::CNT_W-1:0] n_cnt;
    logic                             r_hit;
    logic                             r_alloc;
    logic                             r_failed;
    logic [cte_pkg::SLOT_W-1:0]       r_slot;
    logic                             r_done;
    cte_pkg::t_rsp                    r_rsp;

    logic [cte_pkg::EXT_W-1:0]        slot_n;
    logic [cte_pkg::EXT_W-1:0]        cfg_ext;
    logic [cte_pkg::TAG_W-1:0]        tag_rd;
    logic [cte_pkg::FILE_W-1:0]       tag_file;
    logic [cte_pkg::OFF_W-1:0]        tag_off;
    logic                             is_trunc;
    logic                             match;
    logic [cte_pkg::SLOT_W-1:0]       n_hand_step;

    // effective slot count: zero acts as one, clamp to the array size
    assign cfg_ext = cte_pkg::EXT_W'(r_slots_in_use);
    always_comb begin
        if (r_slots_in_use == '0) begin
            slot_n = cte_pkg::EXT_W'(1);
        end else if (cfg_ext > cte_pkg::EXT_W'(cte_pkg::MAX_SLOTS)) begin
            slot_n = cte_pkg::EXT_W'(cte_pkg::MAX_SLOTS);
        end else begin
            slot_n = cfg_ext;
        end
    end

    // tag store, {file, offset} per slot
    cte_ram #(
        .WIDTH (cte_pkg::TAG_W),
        .DEPTH (cte_pkg::MAX_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill),
        .i_waddr (r_hand),
        .i_wdata ({r_req.file_id, r_req.block_offset}),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_idx),
        .o_rdata (tag_rd)
    );

    assign tag_file = tag_rd[cte_pkg::TAG_W-1 -: cte_pkg::FILE_W];
    assign tag_off  = tag_rd[cte_pkg::OFF_W-1:0];
    assign is_trunc = (r_req.action == cte_pkg::ACT_TRUNC);

    // compare the slot just read; truncate matches offsets at or past new size
    always_comb begin
        match = r_valid[r_idx] && (tag_file == r_req.file_id);
        if (is_trunc) begin
            match = match && (tag_off >= r_req.new_size);
        end else begin
            match = match && (tag_off == r_req.block_offset);
        end
    end

    // next hand position with wrap at the slot count
    assign n_hand_step = (cte_pkg::EXT_W'(r_hand) + 1'b1 >= slot_n) ? '0 : r_hand + 1'b1;

    always_comb begin
        o_status.is_trunc     = is_trunc;
        o_status.is_read      = (r_req.action == cte_pkg::ACT_READ);
        o_status.fetch_failed = r_req.fetch_failed;
        o_status.match        = match;
        o_status.last         = (cte_pkg::EXT_W'(r_idx) + 1'b1 >= slot_n);
        o_status.hand_recent  = r_recent[r_hand];
    end

    // saturating counter update for the finished request
    always_comb begin
        n_cnt = r_cnt;
        if (r_req.action == cte_pkg::ACT_READ) begin
            if (r_hit) begin
                if (r_cnt[cte_pkg::CNT_RD_HIT] != '1) begin
                    n_cnt[cte_pkg::CNT_RD_HIT] = r_cnt[cte_pkg::CNT_RD_HIT] + 1'b1;
                end
            end else if (r_cnt[cte_pkg::CNT_RD_MISS] != '1) begin
                n_cnt[cte_pkg::CNT_RD_MISS] = r_cnt[cte_pkg::CNT_RD_MISS] + 1'b1;
            end
        end else if (r_req.action == cte_pkg::ACT_WRITE) begin
            if (r_hit) begin
                if (r_cnt[cte_pkg::CNT_WR_HIT] != '1) begin
                    n_cnt[cte_pkg::CNT_WR_HIT] = r_cnt[cte_pkg::CNT_WR_HIT] + 1'b1;
                end
            end else if (r_cnt[cte_pkg::CNT_WR_MISS] != '1) begin
                n_cnt[cte_pkg::CNT_WR_MISS] = r_cnt[cte_pkg::CNT_WR_MISS] + 1'b1;
            end
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= cte_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_slots_in_use <= i_cfg_data;
        end
    end

    // marks, hand, counters, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_recent <= '0;
            r_hand   <= '0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.hit_set) begin
                r_recent[r_idx] <= 1'b1;
            end
            if (i_cmd.trunc_clr) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.hand_wrap && (cte_pkg::EXT_W'(r_hand) >= slot_n)) begin
                r_hand <= '0;
            end
            if (i_cmd.hand_step) begin
                r_recent[r_hand] <= 1'b0;
                r_hand           <= n_hand_step;
            end
            if (i_cmd.fill) begin
                r_valid[r_hand]  <= 1'b1;
                r_recent[r_hand] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_cnt <= n_cnt;
            end
        end
    end

    // request latch, scan index and per-request result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_alloc  <= 1'b0;
            r_failed <= 1'b0;
            r_slot   <= '0;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.hit_set) begin
                r_hit  <= 1'b1;
                r_slot <= r_idx;
            end
            if (i_cmd.fail_set) begin
                r_failed <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_alloc <= 1'b1;
                r_slot  <= r_hand;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp.hit          <= r_hit;
            r_rsp.slot         <= cte_pkg::SLOT_OUT_W'(r_slot);
            r_rsp.allocated    <= r_alloc;
            r_rsp.failed       <= r_failed;
            r_rsp.read_hits    <= n_cnt[cte_pkg::CNT_RD_HIT];
            r_rsp.read_misses  <= n_cnt[cte_pkg::CNT_RD_MISS];
            r_rsp.write_hits   <= n_cnt[cte_pkg::CNT_WR_HIT];
            r_rsp.write_misses <= n_cnt[cte_pkg::CNT_WR_MISS];
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

[design/cte_ctrl.sv]
// Controller: tag scan, clock sweep and fill sequencing.
`include "clock_cache_tag_engine_assert.svh"

module cte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cte_pkg::t_action    i_action,
    input  cte_pkg::t_dp_status i_status,
    output cte_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);

    cte_pkg::t_state r_state;
    cte_pkg::t_state n_state;
    logic            accept;

    assign o_busy = (r_state != cte_pkg::ST_IDLE);
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cte_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_action == cte_pkg::ACT_NONE) ? cte_pkg::ST_FINISH
                                                              : cte_pkg::ST_READ;
                end
            end
            cte_pkg::ST_READ: begin
                n_state = cte_pkg::ST_CMP;
            end
            cte_pkg::ST_CMP: begin
                if (i_status.is_trunc) begin
                    n_state = i_status.last ? cte_pkg::ST_FINISH : cte_pkg::ST_READ;
                end else if (i_status.match) begin
                    n_state = cte_pkg::ST_FINISH;
                end else if (!i_status.last) begin
                    n_state = cte_pkg::ST_READ;
                end else if (i_status.is_read && i_status.fetch_failed) begin
                    n_state = cte_pkg::ST_FINISH;
                end else begin
                    n_state = cte_pkg::ST_SWEEP;
                end
            end
            cte_pkg::ST_SWEEP: begin
                if (!i_status.hand_recent) begin
                    n_state = cte_pkg::ST_FILL;
                end
            end
            cte_pkg::ST_FILL: begin
                n_state = cte_pkg::ST_FINISH;
            end
            cte_pkg::ST_FINISH: begin
                n_state = cte_pkg::ST_IDLE;
            end
            default: begin
                n_state = cte_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            cte_pkg::ST_IDLE: begin
                o_cmd.load = accept;
            end
            cte_pkg::ST_READ: begin
                o_cmd.ram_rd = 1'b1;
            end
            cte_pkg::ST_CMP: begin
                if (i_status.is_trunc) begin
                    o_cmd.trunc_clr = i_status.match;
                    o_cmd.idx_inc   = !i_status.last;
                end else if (i_status.match) begin
                    o_cmd.hit_set = 1'b1;
                end else if (!i_status.last) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_status.is_read && i_status.fetch_failed) begin
                    o_cmd.fail_set = 1'b1;
                end else begin
                    o_cmd.hand_wrap = 1'b1;
                end
            end
            cte_pkg::ST_SWEEP: begin
                o_cmd.hand_step = i_status.hand_recent;
            end
            cte_pkg::ST_FILL: begin
                o_cmd.fill = 1'b1;
            end
            cte_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // a new request always starts a scan or goes straight to finish
    `CTE_ASSERT(a_accept_next, i_clk, i_rst_n, accept |=> (r_state == cte_pkg::ST_READ || r_state == cte_pkg::ST_FINISH), "accepted request did not start")
    // a fill is always followed by the finish step
    `CTE_ASSERT(a_fill_finish, i_clk, i_rst_n, o_cmd.fill |=> o_cmd.finish, "fill not followed by finish")
    // the sweep stops on the first slot with a clear recent mark
    `CTE_ASSERT(a_sweep_stop, i_clk, i_rst_n, (r_state == cte_pkg::ST_SWEEP && !i_status.hand_recent) |=> o_cmd.fill, "sweep passed a clear slot")
    // hit, fail and fill are mutually exclusive outcomes
    `CTE_ASSERT_ALWAYS(a_outcome_excl, i_clk, $onehot0({o_cmd.hit_set, o_cmd.fail_set, o_cmd.fill, o_cmd.hand_wrap}), "conflicting lookup outcomes")

endmodule

[verif/tb_clock_cache_tag_engine.sv]
// Self-checking testbench for the clock-replacement cache tag engine.
module tb_clock_cache_tag_engine;

    // cycles without any handshake or result before the run is abandoned
    localparam int IDLE_LIMIT = 2000;
    localparam logic [cte_pkg::FILE_W-1:0] PRELOAD_FILE = 16'h0F0F;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    cte_pkg::t_req                i_req;
    logic                         o_done;
    cte_pkg::t_rsp                o_rsp;
    logic                         i_cfg_we;
    logic [cte_pkg::CFG_W-1:0]    i_cfg_data;

    // predicted engine state
    bit                           cache_valid  [cte_pkg::MAX_SLOTS];
    bit                           cache_recent [cte_pkg::MAX_SLOTS];
    logic [cte_pkg::FILE_W-1:0]   cache_file   [cte_pkg::MAX_SLOTS];
    logic [cte_pkg::OFF_W-1:0]    cache_off    [cte_pkg::MAX_SLOTS];
    int                           sweep_hand = 0;
    logic [cte_pkg::CNT_W-1:0]    access_count [cte_pkg::CNT_NUM] = '{default: '0};
    logic [cte_pkg::CFG_W-1:0]    slot_limit_reg = cte_pkg::CFG_RESET;

    cte_pkg::t_rsp       pending_rsp_q[$];
    cte_pkg::t_rsp       oldest_rsp;
    int                  mismatch_count = 0;
    int                  result_count   = 0;
    int                  sender_idle_pct = 0;
    int                  quiet_cycles   = 0;

    always #5 i_clk = ~i_clk;

    clock_cache_tag_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        foreach (cache_valid[i]) begin
            cache_valid[i]  = 1'b0;
            cache_recent[i] = 1'b0;
            cache_file[i]   = '0;
            cache_off[i]    = '0;
        end
    end

    // Effective slot count: 0 acts as 1, anything above the array size is clamped
    function automatic int live_slots();
        if (slot_limit_reg == 0) begin
            return 1;
        end
        if (slot_limit_reg > cte_pkg::MAX_SLOTS) begin
            return cte_pkg::MAX_SLOTS;
        end
        return int'(slot_limit_reg);
    endfunction

    // Advances the predicted state by one request and returns its result
    function automatic cte_pkg::t_rsp predict_access(cte_pkg::t_req r);
        int            n;
        int            found;
        int            which;
        bit            is_read;
        cte_pkg::t_rsp rsp;
        rsp   = '0;
        n     = live_slots();
        found = -1;
        if (r.action == cte_pkg::ACT_READ || r.action == cte_pkg::ACT_WRITE) begin
            is_read = (r.action == cte_pkg::ACT_READ);
            // lowest valid matching slot wins
            for (int i = 0; i < n; i++) begin
                if (found < 0 && cache_valid[i] && cache_file[i] == r.file_id &&
                    cache_off[i] == r.block_offset) begin
                    found = i;
                end
            end
            if (found >= 0) begin
                rsp.hit             = 1'b1;
                rsp.slot            = cte_pkg::SLOT_OUT_W'(found);
                cache_recent[found] = 1'b1;
                which = is_read ? cte_pkg::CNT_RD_HIT : cte_pkg::CNT_WR_HIT;
            end else begin
                which = is_read ? cte_pkg::CNT_RD_MISS : cte_pkg::CNT_WR_MISS;
                if (is_read && r.fetch_failed) begin
                    rsp.failed = 1'b1;
                end else begin
                    // clock sweep: give recently used slots a second chance
                    if (sweep_hand >= n) begin
                        sweep_hand = 0;
                    end
                    while (cache_recent[sweep_hand]) begin
                        cache_recent[sweep_hand] = 1'b0;
                        sweep_hand = (sweep_hand + 1 >= n) ? 0 : sweep_hand + 1;
                    end
                    cache_valid[sweep_hand]  = 1'b1;
                    cache_recent[sweep_hand] = 1'b1;
                    cache_file[sweep_hand]   = r.file_id;
                    cache_off[sweep_hand]    = r.block_offset;
                    rsp.slot      = cte_pkg::SLOT_OUT_W'(sweep_hand);
                    rsp.allocated = 1'b1;
                end
            end
            if (access_count[which] != '1) begin
                access_count[which] = access_count[which] + 1'b1;
            end
        end else if (r.action == cte_pkg::ACT_TRUNC) begin
            for (int i = 0; i < n; i++) begin
                if (cache_valid[i] && cache_file[i] == r.file_id &&
                    cache_off[i] >= r.new_size) begin
                    cache_valid[i] = 1'b0;
                end
            end
        end
        rsp.read_hits    = access_count[cte_pkg::CNT_RD_HIT];
        rsp.read_misses  = access_count[cte_pkg::CNT_RD_MISS];
        rsp.write_hits   = access_count[cte_pkg::CNT_WR_HIT];
        rsp.write_misses = access_count[cte_pkg::CNT_WR_MISS];
        return rsp;
    endfunction

    function automatic cte_pkg::t_req make_req(cte_pkg::t_action act,
                                               logic [cte_pkg::FILE_W-1:0] file_id,
                                               logic [cte_pkg::OFF_W-1:0] offset,
                                               logic [cte_pkg::OFF_W-1:0] new_size,
                                               logic fetch_failed);
        cte_pkg::t_req r;
        r.action       = act;
        r.file_id      = file_id;
        r.block_offset = offset;
        r.new_size     = new_size;
        r.fetch_failed = fetch_failed;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Sends one request, idling first at random; start stays high after acceptance
    task automatic send_request(input cte_pkg::t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_rsp_q.push_back(predict_access(r));
    endtask

    // Drop start and wait until every predicted result has come back
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [cte_pkg::CFG_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        slot_limit_reg = value;
    endtask

    // Fill every slot once so each tag entry holds a written value
    task automatic test_preload_fill();
        for (int i = 0; i < cte_pkg::MAX_SLOTS; i++) begin
            send_request(make_req(cte_pkg::ACT_WRITE, PRELOAD_FILE, cte_pkg::OFF_W'(i),
                                  '0, 1'b0));
        end
    endtask

    // Hits, misses, failed fetches and the unused action code
    task automatic test_lookup_cases();
        send_request(make_req(cte_pkg::ACT_READ,  PRELOAD_FILE, 24'd0,  '0, 1'b1));
        send_request(make_req(cte_pkg::ACT_WRITE, PRELOAD_FILE, 24'd63, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  16'h0000, 24'h000000, '0, 1'b1));
        send_request(make_req(cte_pkg::ACT_READ,  16'h0000, 24'h000000, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  16'h0000, 24'h000000, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_WRITE, 16'hFFFF, 24'hFFFFFF, '0, 1'b1));
        send_request(make_req(cte_pkg::ACT_WRITE, 16'hFFFF, 24'hFFFFFF, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  16'hFFFF, 24'hFFFFFF, '0, 1'b1));
        send_request(make_req(cte_pkg::ACT_NONE,  16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
        send_request(make_req(cte_pkg::ACT_WRITE, 16'hFFFF, 24'h000000, '0, 1'b0));
    endtask

    // Truncate at size extremes and in the middle of a file
    task automatic test_truncate();
        send_request(make_req(cte_pkg::ACT_TRUNC, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
        send_request(make_req(cte_pkg::ACT_READ,  16'hFFFF, 24'hFFFFFF, '0, 1'b1));
        send_request(make_req(cte_pkg::ACT_READ,  16'hFFFF, 24'h000000, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_TRUNC, PRELOAD_FILE, '0, 24'd32, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  PRELOAD_FILE, 24'd40, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  PRELOAD_FILE, 24'd31, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_TRUNC, 16'h1234, '0, 24'd0, 1'b0));
        send_request(make_req(cte_pkg::ACT_TRUNC, PRELOAD_FILE, '0, 24'd0, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  PRELOAD_FILE, 24'd5, '0, 1'b1));
    endtask

    // Slot count extremes, hand past the count, duplicate tags above the count
    task automatic test_slot_limits();
        write_config(7'd127);
        send_request(make_req(cte_pkg::ACT_WRITE, 16'hABCD, 24'd9, '0, 1'b0));
        write_config(7'd2);
        send_request(make_req(cte_pkg::ACT_WRITE, 16'hABCD, 24'd9, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_WRITE, 16'hABCD, 24'd7, '0, 1'b0));
        write_config(7'd0);
        send_request(make_req(cte_pkg::ACT_WRITE, 16'h0001, 24'd1, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_WRITE, 16'h0001, 24'd2, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  16'h0001, 24'd1, '0, 1'b0));
        write_config(7'd1);
        send_request(make_req(cte_pkg::ACT_READ,  16'h0001, 24'd1, '0, 1'b0));
        write_config(7'd65);
        send_request(make_req(cte_pkg::ACT_READ,  16'hABCD, 24'd9, '0, 1'b0));
        send_request(make_req(cte_pkg::ACT_TRUNC, 16'hABCD, '0, 24'd8, 1'b0));
        send_request(make_req(cte_pkg::ACT_READ,  16'hABCD, 24'd9, '0, 1'b1));
    endtask

    // Random traffic over a small pool of files and offsets so that tags repeat
    task automatic test_random_traffic(input int per_segment);
        logic [cte_pkg::FILE_W-1:0] files [4];
        logic [cte_pkg::OFF_W-1:0]  bases [4];
        logic [cte_pkg::CFG_W-1:0]  seg_cfg [6];
        int                         span;
        int                         pick;
        int                         roll;
        cte_pkg::t_req              r;
        seg_cfg = '{7'd64, 7'd5, 7'd127, 7'd0, 7'd17, 7'd64};
        for (int seg = 0; seg < 6; seg++) begin
            sender_idle_pct = (seg < 2) ? 26 : (seg < 4) ? 81 : 0;
            write_config((seg == 5) ? cte_pkg::CFG_W'($urandom_range(64, 1)) : seg_cfg[seg]);
            for (int j = 0; j < 3; j++) begin
                files[j] = cte_pkg::FILE_W'($urandom);
                bases[j] = cte_pkg::OFF_W'($urandom);
            end
            files[3] = (seg % 2) ? 16'hFFFF : 16'h0000;
            bases[3] = (seg % 2) ? 24'hFFFFF8 : 24'h000000;
            span = $urandom_range(16, 2);
            for (int k = 0; k < per_segment; k++) begin
                roll = $urandom_range(99);
                pick = $urandom_range(3);
                r.file_id      = files[pick];
                r.block_offset = bases[pick] + cte_pkg::OFF_W'($urandom_range(span - 1));
                r.new_size     = bases[pick] + cte_pkg::OFF_W'($urandom_range(span));
                r.fetch_failed = ($urandom_range(3) == 0);
                if (roll < 45) begin
                    r.action = cte_pkg::ACT_READ;
                end else if (roll < 80) begin
                    r.action = cte_pkg::ACT_WRITE;
                end else if (roll < 92) begin
                    r.action = cte_pkg::ACT_TRUNC;
                    if ($urandom_range(7) == 0) begin
                        r.new_size = '0;
                    end
                end else if (roll < 95) begin
                    r.action = cte_pkg::ACT_NONE;
                end else begin
                    // noise: every field fully random
                    r.action       = cte_pkg::t_action'($urandom_range(3));
                    r.file_id      = cte_pkg::FILE_W'($urandom);
                    r.block_offset = cte_pkg::OFF_W'($urandom);
                    r.new_size     = cte_pkg::OFF_W'($urandom);
                    r.fetch_failed = 1'($urandom_range(1));
                end
                send_request(r);
            end
        end
    endtask

    // Result checker: each strobe is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            result_count++;
            if (pending_rsp_q.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                oldest_rsp = pending_rsp_q.pop_front();
                compare_field("hit",          o_rsp.hit,          oldest_rsp.hit);
                compare_field("slot",         o_rsp.slot,         oldest_rsp.slot);
                compare_field("allocated",    o_rsp.allocated,    oldest_rsp.allocated);
                compare_field("failed",       o_rsp.failed,       oldest_rsp.failed);
                compare_field("read_hits",    o_rsp.read_hits,    oldest_rsp.read_hits);
                compare_field("read_misses",  o_rsp.read_misses,  oldest_rsp.read_misses);
                compare_field("write_hits",   o_rsp.write_hits,   oldest_rsp.write_hits);
                compare_field("write_misses", o_rsp.write_misses, oldest_rsp.write_misses);
            end
        end
    end

    // Watchdog: no request accepted and no result for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= cte_pkg::CFG_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 0;
        test_preload_fill();
        sender_idle_pct = 26;
        test_lookup_cases();
        test_truncate();
        test_slot_limits();
        test_random_traffic(170);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/cte_pkg.sv
design/cte_ram.sv
design/cte_datapath.sv
design/cte_ctrl.sv
design/clock_cache_tag_engine.sv
verif/tb_clock_cache_tag_engine.sv
